@@ rtl/pcfs_pkg.sv @@
// ----------------------------------------------------------------------------
// Palette color fade stepper package
// Shared widths, the direction code, the reset palette and the channel
// control bundle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package pcfs_pkg;

	localparam int CHAN_W      = 8;
	localparam int HALF_W      = CHAN_W + 1;
	localparam int COLOR_W     = 3 * CHAN_W;
	localparam int PTR_W       = 3;
	localparam int NUM_ENTRIES = 1 << PTR_W;
	localparam int NUM_REGS    = 6;

	localparam logic [HALF_W-1:0] HALF_MAX = 9'd510;

	typedef logic [CHAN_W-1:0]  chan_t;
	typedef logic [HALF_W-1:0]  half_t;
	typedef logic [COLOR_W-1:0] color_t;
	typedef logic [PTR_W-1:0]   ptr_t;

	typedef enum logic [1:0] {
		DIR_HOLD = 2'd0,
		DIR_UP   = 2'd1,
		DIR_DOWN = 2'd2
	} dir_t;

	// Control shared by the three channel slices for one transfer.
	typedef struct packed {
		logic restart;   // load the start color
		logic retarget;  // recompute the direction against the new target
	} chan_ctrl_t;

	localparam color_t PALETTE_RESET [NUM_REGS] = '{
		24'hFF0000, 24'hFFFF00, 24'hEBAD2A, 24'h008080, 24'h0000FF, 24'h800080
	};

endpackage

`default_nettype wire

@@ rtl/pcfs_palette.sv @@
// ----------------------------------------------------------------------------
// Palette register file
// Holds the target colors, compares the current color against every entry
// in parallel and reads out the entry being approached.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module pcfs_palette (
	input  wire                                  clk,
	input  wire                                  arst_n,
	input  wire                                  cfg_write,
	input  wire  pcfs_pkg::ptr_t                 cfg_index,
	input  wire  pcfs_pkg::color_t               cfg_data,
	input  wire  pcfs_pkg::chan_t                cur_red,
	input  wire  pcfs_pkg::chan_t                cur_green,
	input  wire  pcfs_pkg::chan_t                cur_blue,
	output logic [pcfs_pkg::NUM_ENTRIES-1:0]     match_vec,
	input  wire  pcfs_pkg::ptr_t                 rd_sel,
	output pcfs_pkg::color_t                     rd_color
);
	import pcfs_pkg::*;

	color_t entry [NUM_ENTRIES];

	for (genvar k = 0; k < NUM_ENTRIES; k++) begin : g_entry
		if (k < NUM_REGS) begin : g_reg
			color_t color_q;

			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					color_q <= PALETTE_RESET[k];
				end else if (cfg_write && (cfg_index == ptr_t'(k))) begin
					color_q <= cfg_data;
				end
			end

			assign entry[k] = color_q;
		end else begin : g_black
			// Entries past the register set are fixed black.
			assign entry[k] = '0;
		end

		assign match_vec[k] = (entry[k][23:16] == cur_red) &&
		                      (entry[k][15:8]  == cur_green) &&
		                      (entry[k][7:0]   == cur_blue);
	end

	assign rd_color = entry[rd_sel];

endmodule

`default_nettype wire

@@ rtl/pcfs_channel.sv @@
// ----------------------------------------------------------------------------
// Channel step slice
// Next half-step value and direction of one color channel.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module pcfs_channel (
	input  wire  pcfs_pkg::chan_ctrl_t ctrl,
	input  wire  pcfs_pkg::chan_t      start_level,
	input  wire  pcfs_pkg::chan_t      target_level,
	input  wire  pcfs_pkg::half_t      half_cur,
	input  wire  pcfs_pkg::dir_t       dir_cur,
	output pcfs_pkg::half_t            half_next,
	output pcfs_pkg::dir_t             dir_next
);
	import pcfs_pkg::*;

	half_t half_base;
	half_t target_half;
	logic  off_target;

	assign half_base   = ctrl.restart ? {start_level, 1'b0} : half_cur;
	assign target_half = {target_level, 1'b0};
	assign off_target  = (half_base != target_half);

	always_comb begin
		if (ctrl.retarget) begin
			if (half_base < target_half) begin
				dir_next = DIR_UP;
			end else if (half_base > target_half) begin
				dir_next = DIR_DOWN;
			end else begin
				dir_next = DIR_HOLD;
			end
		end else begin
			dir_next = dir_cur;
		end
	end

	// A channel can be pushed away from its target after a palette change,
	// so the step saturates at both ends of the range.
	always_comb begin
		half_next = half_base;
		case (dir_next)
			DIR_UP: begin
				if (off_target && (half_base < HALF_MAX)) begin
					half_next = half_base + half_t'(1);
				end
			end
			DIR_DOWN: begin
				if (off_target && (half_base != '0)) begin
					half_next = half_base - half_t'(1);
				end
			end
			default: begin
				half_next = half_base;
			end
		endcase
	end

endmodule

`default_nettype wire

@@ rtl/palette_color_fade_stepper.sv @@
// ----------------------------------------------------------------------------
// Palette color fade stepper
// Fades an RGB color through a palette of target colors, half a level per
// tick and channel.
// ----------------------------------------------------------------------------
// The block takes one item per clock cycle while in_stall is low and returns
// exactly one result for each item: the item is captured in an input
// register, and when it is processed the whole color update (target match
// against every palette entry, pointer advance, direction choice and the
// half-level step of each channel) settles between that register and the
// result register while the fade state is written back. The state update
// loop through the fade registers sets the rate. The result register holds a
// finished result while it waits on out_stall, and the input register keeps
// accepting until both are full, so in_stall rises only when a result is held
// and another item is already waiting behind it. A restart item (func = 1)
// loads the start color, aims at palette entry 0 and picks each channel's
// direction; a tick item (func = 0) first moves on to the next entry, wrapping
// after entry PALETTE_SIZE-1, when the displayed color equals the current
// target. Each channel keeps one fraction bit, so a displayed level changes
// every second tick. The palette registers are written through the cfg port
// (index 0 to 5, other indexes are ignored) and should only be changed while
// no transfer is in flight; entries 6 and 7 read as black. After reset all
// channels hold at black until a restart arrives or the target is black.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module palette_color_fade_stepper #(
	parameter int PALETTE_SIZE = 6
) (
	input  wire                     clk,
	input  wire                     arst_n,
	// Palette configuration
	input  wire                     cfg_write,
	input  wire  pcfs_pkg::ptr_t    cfg_index,
	input  wire  pcfs_pkg::color_t  cfg_data,
	// Item input channel
	input  wire                     in_valid,
	output logic                    in_stall,
	input  wire                     func,
	input  wire  pcfs_pkg::chan_t   start_red,
	input  wire  pcfs_pkg::chan_t   start_green,
	input  wire  pcfs_pkg::chan_t   start_blue,
	// Result channel
	output logic                    out_valid,
	input  wire                     out_stall,
	output pcfs_pkg::chan_t         out_red,
	output pcfs_pkg::chan_t         out_green,
	output pcfs_pkg::chan_t         out_blue,
	output pcfs_pkg::ptr_t          target_number
);
	import pcfs_pkg::*;

	localparam logic [PTR_W:0] SIZE = (PTR_W + 1)'(PALETTE_SIZE);

	// Input register
	logic  valid_s1;
	logic  func_s1;
	chan_t start_red_s1;
	chan_t start_green_s1;
	chan_t start_blue_s1;

	// Fade state
	half_t red_half_q, green_half_q, blue_half_q;
	dir_t  red_dir_q, green_dir_q, blue_dir_q;
	ptr_t  ptr_q;

	// Result register
	logic  out_valid_q;
	chan_t res_red_q, res_green_q, res_blue_q;
	ptr_t  res_ptr_q;

	logic                   in_take;
	logic                   advance;
	logic [NUM_ENTRIES-1:0] match_vec;
	logic [PTR_W:0]         ptr_inc;
	ptr_t                   ptr_wrap;
	ptr_t                   ptr_new;
	color_t                 target_color;
	chan_ctrl_t             ctrl;
	half_t                  red_half_d, green_half_d, blue_half_d;
	dir_t                   red_dir_d, green_dir_d, blue_dir_d;

	// The item in the input register is processed when the result register
	// is empty or its result is transferred in this cycle.
	assign advance  = valid_s1 && (!out_valid_q || !out_stall);
	assign in_stall = valid_s1 && !advance;
	assign in_take  = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= in_take || (valid_s1 && !advance);
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			func_s1        <= func;
			start_red_s1   <= start_red;
			start_green_s1 <= start_green;
			start_blue_s1  <= start_blue;
		end
	end

	// Every entry is compared with the displayed color at once; the pointer
	// only selects one match bit and the color of the new target.
	pcfs_palette u_palette (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_write (cfg_write),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cur_red   (red_half_q[HALF_W-1:1]),
		.cur_green (green_half_q[HALF_W-1:1]),
		.cur_blue  (blue_half_q[HALF_W-1:1]),
		.match_vec (match_vec),
		.rd_sel    (ptr_new),
		.rd_color  (target_color)
	);

	assign ptr_inc  = {1'b0, ptr_q} + (PTR_W + 1)'(1);
	assign ptr_wrap = (ptr_inc >= SIZE) ? '0 : ptr_inc[PTR_W-1:0];

	always_comb begin
		ctrl.restart  = func_s1;
		ctrl.retarget = func_s1 || match_vec[ptr_q];
		if (func_s1) begin
			ptr_new = '0;
		end else if (match_vec[ptr_q]) begin
			ptr_new = ptr_wrap;
		end else begin
			ptr_new = ptr_q;
		end
	end

	pcfs_channel u_red (
		.ctrl         (ctrl),
		.start_level  (start_red_s1),
		.target_level (target_color[23:16]),
		.half_cur     (red_half_q),
		.dir_cur      (red_dir_q),
		.half_next    (red_half_d),
		.dir_next     (red_dir_d)
	);

	pcfs_channel u_green (
		.ctrl         (ctrl),
		.start_level  (start_green_s1),
		.target_level (target_color[15:8]),
		.half_cur     (green_half_q),
		.dir_cur      (green_dir_q),
		.half_next    (green_half_d),
		.dir_next     (green_dir_d)
	);

	pcfs_channel u_blue (
		.ctrl         (ctrl),
		.start_level  (start_blue_s1),
		.target_level (target_color[7:0]),
		.half_cur     (blue_half_q),
		.dir_cur      (blue_dir_q),
		.half_next    (blue_half_d),
		.dir_next     (blue_dir_d)
	);

	// Fade state is written back in the same cycle, so the next item in the
	// input register already sees it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			red_half_q   <= '0;
			green_half_q <= '0;
			blue_half_q  <= '0;
			red_dir_q    <= DIR_HOLD;
			green_dir_q  <= DIR_HOLD;
			blue_dir_q   <= DIR_HOLD;
			ptr_q        <= '0;
		end else if (advance) begin
			red_half_q   <= red_half_d;
			green_half_q <= green_half_d;
			blue_half_q  <= blue_half_d;
			red_dir_q    <= red_dir_d;
			green_dir_q  <= green_dir_d;
			blue_dir_q   <= blue_dir_d;
			ptr_q        <= ptr_new;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_red_q   <= red_half_d[HALF_W-1:1];
			res_green_q <= green_half_d[HALF_W-1:1];
			res_blue_q  <= blue_half_d[HALF_W-1:1];
			res_ptr_q   <= ptr_new;
		end
	end

	assign out_valid     = out_valid_q;
	assign out_red       = res_red_q;
	assign out_green     = res_green_q;
	assign out_blue      = res_blue_q;
	assign target_number = res_ptr_q;

	// The pointer never leaves the active part of the palette.
	a_ptr_range: assert property (@(posedge clk) disable iff (!arst_n)
		{1'b0, ptr_q} < SIZE)
		else $error("target pointer outside the palette");

	// Channel values stay within the 0 to 255.0 range.
	a_half_range: assert property (@(posedge clk) disable iff (!arst_n)
		(red_half_q <= HALF_MAX) && (green_half_q <= HALF_MAX) &&
		(blue_half_q <= HALF_MAX))
		else $error("channel half-step value out of range");

	// A processed item always leaves a result behind.
	a_advance_result: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> out_valid_q)
		else $error("processed item produced no result");

	// A restart always aims at the first palette entry.
	a_restart_entry0: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && func_s1) |=> (res_ptr_q == '0) && (ptr_q == '0))
		else $error("restart did not select palette entry 0");

endmodule

`default_nettype wire
